// File: rtl/core/btsq_pkg.sv
// shared types and constants for the box table snap query unit
package btsq_pkg;

  localparam int MAX_BOXES_DEF  = 256;
  localparam int COORD_BITS_DEF = 14;
  localparam int MIN_AREA_RST   = 32;
  localparam int FUNC_W         = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 3'd0,
    FN_ADD     = 3'd1,
    FN_CONTAIN = 3'd2,
    FN_BEGIN   = 3'd3,
    FN_END     = 3'd4
  } func_t;

  // control from the sequencer to the scan datapath
  typedef struct packed {
    logic  init;  // load the accumulators for a new item
    logic  hit;   // read data of one entry is on the memory output
    func_t func;  // operation of the item in flight
  } scan_ctl_t;

endpackage

// File: rtl/core/btsq_box_mem.sv
// box store: one write port, one read port with registered data
module btsq_box_mem #(
  parameter int DEPTH  = btsq_pkg::MAX_BOXES_DEF,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 4 * btsq_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] box_mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= box_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/btsq_scan.sv
// per-entry evaluation stage and running best accumulators for the queries
module btsq_scan #(
  parameter int COORD_BITS = btsq_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btsq_pkg::scan_ctl_t          ctl,
  input  logic [2*COORD_BITS:0]        area_limit,
  input  logic [COORD_BITS-1:0]        q_px,
  input  logic [COORD_BITS-1:0]        q_py,
  input  logic signed [COORD_BITS+1:0] q_right,
  input  logic signed [COORD_BITS+1:0] q_bottom,
  input  logic [4*COORD_BITS-1:0]      rd_data,
  output logic                         busy,
  output logic [COORD_BITS:0]          res_x,
  output logic [COORD_BITS:0]          res_y,
  output logic [COORD_BITS-1:0]        res_w,
  output logic [COORD_BITS-1:0]        res_h
);

  localparam int CB = COORD_BITS;
  localparam int SW = CB + 2;   // signed coordinate, covers -1 .. 2*max
  localparam int MW = CB + 1;   // one axis distance
  localparam int DW = CB + 2;   // manhattan distance
  localparam int AW = 2 * CB;   // box area

  // ---------------- stage 2: evaluate one entry ----------------
  logic [CB-1:0]        bx, by, bw, bh;
  logic signed [SW-1:0] bx_s, by_s, r_s, b_s, px_s, py_s;
  logic [AW-1:0]        area_c;
  logic                 ok_c, contain_c;
  logic signed [SW-1:0] cx_c [4];
  logic signed [SW-1:0] cy_c [4];
  logic [DW-1:0]        dist_c [4];
  logic                 ins_c [4];
  logic [MW-1:0]        dx_c [4];
  logic [MW-1:0]        dy_c [4];

  logic                 v2_r;
  logic                 ok_r, contain_r;
  logic [AW-1:0]        area_r;
  logic [CB-1:0]        bx_r, by_r, bw_r, bh_r;
  logic signed [SW-1:0] cx_r [4];
  logic signed [SW-1:0] cy_r [4];
  logic [DW-1:0]        dist_r [4];
  logic                 ins_r [4];
  logic [MW-1:0]        dx_r [4];
  logic [MW-1:0]        dy_r [4];

  always_comb begin
    logic signed [SW-1:0] ddx, ddy;
    logic [SW-1:0]        ax, ay;
    logic signed [SW-1:0] ex, ey;
    bx = rd_data[4*CB-1 -: CB];
    by = rd_data[3*CB-1 -: CB];
    bw = rd_data[2*CB-1 -: CB];
    bh = rd_data[CB-1 -: CB];
    bx_s = signed'({2'b00, bx});
    by_s = signed'({2'b00, by});
    px_s = signed'({2'b00, q_px});
    py_s = signed'({2'b00, q_py});
    r_s  = bx_s + signed'({2'b00, bw}) - SW'(1);
    b_s  = by_s + signed'({2'b00, bh}) - SW'(1);
    area_c = {{CB{1'b0}}, bw} * {{CB{1'b0}}, bh};
    ok_c   = {1'b0, area_c} >= area_limit;
    contain_c = ({1'b0, q_px} >= {1'b0, bx}) &&
                ({1'b0, q_px} < ({1'b0, bx} + {1'b0, bw})) &&
                ({1'b0, q_py} >= {1'b0, by}) &&
                ({1'b0, q_py} < ({1'b0, by} + {1'b0, bh}));
    // corners in order top-left, top-right, bottom-left, bottom-right
    cx_c[0] = bx_s; cy_c[0] = by_s;
    cx_c[1] = r_s;  cy_c[1] = by_s;
    cx_c[2] = bx_s; cy_c[2] = b_s;
    cx_c[3] = r_s;  cy_c[3] = b_s;
    for (int k = 0; k < 4; k++) begin
      ddx = px_s - cx_c[k];
      ddy = py_s - cy_c[k];
      ax  = ddx[SW-1] ? unsigned'(-ddx) : unsigned'(ddx);
      ay  = ddy[SW-1] ? unsigned'(-ddy) : unsigned'(ddy);
      dist_c[k] = {1'b0, ax[MW-1:0]} + {1'b0, ay[MW-1:0]};
      ins_c[k]  = (cx_c[k] >= px_s) && (cx_c[k] <= q_right) &&
                  (cy_c[k] >= py_s) && (cy_c[k] <= q_bottom);
      // corner inside the rectangle, so both differences are non-negative
      ex = q_right - cx_c[k];
      ey = q_bottom - cy_c[k];
      dx_c[k] = ex[MW-1:0];
      dy_c[k] = ey[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= ctl.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit) begin
      ok_r      <= ok_c;
      contain_r <= contain_c;
      area_r    <= area_c;
      bx_r      <= bx;
      by_r      <= by;
      bw_r      <= bw;
      bh_r      <= bh;
      for (int k = 0; k < 4; k++) begin
        cx_r[k]   <= cx_c[k];
        cy_r[k]   <= cy_c[k];
        dist_r[k] <= dist_c[k];
        ins_r[k]  <= ins_c[k];
        dx_r[k]   <= dx_c[k];
        dy_r[k]   <= dy_c[k];
      end
    end
  end

  assign busy = v2_r;

  // ---------------- stage 3: fold into running best ----------------
  logic                 found_r, found_nxt;
  logic                 fy_r, fy_nxt;
  logic [AW-1:0]        best_area_r, best_area_nxt;
  logic [DW-1:0]        best_d_r, best_d_nxt;
  logic [MW-1:0]        bdy_r, bdy_nxt;
  logic signed [SW-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [CB-1:0]        rw_r, rw_nxt, rh_r, rh_nxt;

  // found/best_d double as the x tracker for the end snap
  always_comb begin
    found_nxt     = found_r;
    fy_nxt        = fy_r;
    best_area_nxt = best_area_r;
    best_d_nxt    = best_d_r;
    bdy_nxt       = bdy_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rw_nxt        = rw_r;
    rh_nxt        = rh_r;
    if (ctl.init) begin
      found_nxt = 1'b0;
      fy_nxt    = 1'b0;
      rw_nxt    = '0;
      rh_nxt    = '0;
      case (ctl.func)
        btsq_pkg::FN_BEGIN: begin
          rx_nxt = px_s;
          ry_nxt = py_s;
        end
        btsq_pkg::FN_END: begin
          rx_nxt = q_right;
          ry_nxt = q_bottom;
        end
        default: begin
          rx_nxt = '0;
          ry_nxt = '0;
        end
      endcase
    end else if (v2_r && ok_r) begin
      case (ctl.func)
        btsq_pkg::FN_CONTAIN: begin
          if (contain_r && (!found_r || area_r < best_area_r)) begin
            found_nxt     = 1'b1;
            best_area_nxt = area_r;
            rx_nxt        = signed'({2'b00, bx_r});
            ry_nxt        = signed'({2'b00, by_r});
            rw_nxt        = bw_r;
            rh_nxt        = bh_r;
          end
        end
        btsq_pkg::FN_BEGIN: begin
          for (int k = 0; k < 4; k++) begin
            if (!found_nxt || dist_r[k] < best_d_nxt) begin
              found_nxt  = 1'b1;
              best_d_nxt = dist_r[k];
              rx_nxt     = cx_r[k];
              ry_nxt     = cy_r[k];
            end
          end
        end
        btsq_pkg::FN_END: begin
          for (int k = 0; k < 4; k++) begin
            if (ins_r[k]) begin
              if (!found_nxt || {1'b0, dx_r[k]} < best_d_nxt) begin
                found_nxt  = 1'b1;
                best_d_nxt = {1'b0, dx_r[k]};
                rx_nxt     = cx_r[k];
              end
              if (!fy_nxt || dy_r[k] < bdy_nxt) begin
                fy_nxt  = 1'b1;
                bdy_nxt = dy_r[k];
                ry_nxt  = cy_r[k];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      fy_r    <= 1'b0;
    end else begin
      found_r <= found_nxt;
      fy_r    <= fy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_area_r <= best_area_nxt;
    best_d_r    <= best_d_nxt;
    bdy_r       <= bdy_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    rw_r        <= rw_nxt;
    rh_r        <= rh_nxt;
  end

  // end snap landing on the top-left corner falls back to bottom-right,
  // negative edges clamp to zero
  always_comb begin
    logic signed [SW-1:0] fx, fy;
    fx = rx_r;
    fy = ry_r;
    if (ctl.func == btsq_pkg::FN_END && rx_r == px_s && ry_r == py_s) begin
      fx = q_right;
      fy = q_bottom;
    end
    res_x = fx[SW-1] ? '0 : fx[CB:0];
    res_y = fy[SW-1] ? '0 : fy[CB:0];
    res_w = rw_r;
    res_h = rh_r;
  end

endmodule

// File: rtl/core/box_table_snap_query_unit.sv
// top level: item sequencer, box count, config register and result register
// sequence: clear, add, other codes and queries on an empty table go from start
//   to done; a query goes start, scan over the stored boxes, drain, done
// throughput: one item at a time, the scan reads one entry per cycle
// reset: box count 0, min_box_area 32, result register empty; box memory is
//   not cleared, entries at or above the count are never read
module box_table_snap_query_unit #(
  parameter int MAX_BOXES  = btsq_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = btsq_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2*COORD_BITS:0]         cfg_min_box_area,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btsq_pkg::FUNC_W-1:0]   in_func,
  input  logic [COORD_BITS-1:0]         in_pos_x,
  input  logic [COORD_BITS-1:0]         in_pos_y,
  input  logic [COORD_BITS-1:0]         in_size_w,
  input  logic [COORD_BITS-1:0]         in_size_h,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_BITS:0]           out_x,
  output logic [COORD_BITS:0]           out_y,
  output logic [COORD_BITS-1:0]         out_w,
  output logic [COORD_BITS-1:0]         out_h,
  output logic                          out_table_full,
  output logic [$clog2(MAX_BOXES+1)-1:0] out_entries
);

  localparam int CB = COORD_BITS;
  localparam int SW = CB + 2;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int DATA_W = 4 * CB;
  localparam int AREA_W = 2 * CB + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // config register, written any time (only changed while idle by contract)
  logic [AREA_W-1:0] area_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_limit_r <= AREA_W'(btsq_pkg::MIN_AREA_RST);
    end else if (cfg_valid && cfg_ready) begin
      area_limit_r <= cfg_min_box_area;
    end
  end

  // item latched at the input transfer
  btsq_pkg::func_t      q_func_r;
  logic [CB-1:0]        q_px_r, q_py_r;
  logic signed [SW-1:0] q_right_r, q_bottom_r;
  logic signed [SW-1:0] right_c, bottom_c;

  logic [CW-1:0] count_r;
  logic          full_r;
  logic [IW-1:0] idx_r;
  logic          rd_pend_r;
  logic          accept;
  logic          is_full;
  logic          is_query;
  logic          last_idx;
  logic          out_free;
  logic          load_out;
  logic          mem_we;
  logic          mem_re;
  logic          scan_busy;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CW'(MAX_BOXES));
  assign mem_we   = accept && (btsq_pkg::func_t'(in_func) == btsq_pkg::FN_ADD) && !is_full;
  assign mem_re   = (state_r == S_SCAN);
  assign last_idx = ({{(CW-IW){1'b0}}, idx_r} == (count_r - CW'(1)));
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  // rectangle edges for the end snap, may be -1 on a zero size
  assign right_c  = signed'({2'b00, in_pos_x}) + signed'({2'b00, in_size_w}) - SW'(1);
  assign bottom_c = signed'({2'b00, in_pos_y}) + signed'({2'b00, in_size_h}) - SW'(1);

  always_comb begin
    case (q_func_r) inside
      btsq_pkg::FN_CONTAIN, btsq_pkg::FN_BEGIN, btsq_pkg::FN_END: is_query = 1'b1;
      default: is_query = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_func_r   <= btsq_pkg::func_t'(in_func);
      q_px_r     <= in_pos_x;
      q_py_r     <= in_pos_y;
      q_right_r  <= right_c;
      q_bottom_r <= bottom_c;
    end
  end

  // sequencer: start loads the accumulators, scan streams entries out of
  // memory, drain waits for the two pipeline stages behind the read
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (is_query && count_r != '0) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_pend_r && !scan_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      full_r    <= 1'b0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= mem_re;
      if (accept) begin
        full_r <= 1'b0;
        case (btsq_pkg::func_t'(in_func))
          btsq_pkg::FN_CLEAR: count_r <= '0;
          btsq_pkg::FN_ADD: begin
            if (is_full) begin
              full_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (state_r == S_START) begin
        idx_r <= '0;
      end else if (mem_re) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // box memory: {x, y, w, h}
  logic [DATA_W-1:0] rd_data;

  btsq_box_mem #(
    .DEPTH  (MAX_BOXES),
    .ADDR_W (IW),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[IW-1:0]),
    .wr_data ({in_pos_x, in_pos_y, in_size_w, in_size_h}),
    .rd_en   (mem_re),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  btsq_pkg::scan_ctl_t scan_ctl;
  logic [CB:0]         res_x, res_y;
  logic [CB-1:0]       res_w, res_h;

  // fields in order: init, hit, func
  assign scan_ctl = {(state_r == S_START), rd_pend_r, q_func_r};

  btsq_scan #(
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .area_limit (area_limit_r),
    .q_px       (q_px_r),
    .q_py       (q_py_r),
    .q_right    (q_right_r),
    .q_bottom   (q_bottom_r),
    .rd_data    (rd_data),
    .busy       (scan_busy),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_w      (res_w),
    .res_h      (res_h)
  );

  // result register, holds while the consumer stalls
  logic          out_valid_r;
  logic [CB:0]   out_x_r, out_y_r;
  logic [CB-1:0] out_w_r, out_h_r;
  logic          out_full_r;
  logic [CW-1:0] out_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r       <= res_x;
      out_y_r       <= res_y;
      out_w_r       <= res_w;
      out_h_r       <= res_h;
      out_full_r    <= full_r;
      out_entries_r <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_w          = out_w_r;
  assign out_h          = out_h_r;
  assign out_table_full = out_full_r;
  assign out_entries    = out_entries_r;

endmodule

// File: test/box_table_snap_query_unit_tb.sv
// self-checking testbench for the box table snap query unit
module box_table_snap_query_unit_tb;
  import btsq_pkg::*;

  localparam int CB     = COORD_BITS_DEF;
  localparam int NBOX   = MAX_BOXES_DEF;
  localparam int CMAX   = (1 << CB) - 1;
  localparam int FN_TOP = (1 << FUNC_W) - 1;   // codes above FN_END do nothing
  localparam int WIN    = 300;                 // span of one scene's window

  // one result transfer as the block presents it
  typedef struct packed {
    logic [CB:0]   out_x;
    logic [CB:0]   out_y;
    logic [CB-1:0] out_w;
    logic [CB-1:0] out_h;
    logic          table_full;
    logic [8:0]    entries;
  } answer_t;

  // shadow of the box table, predicting one answer per accepted item
  class box_table_mirror;
    int          box_x [NBOX];
    int          box_y [NBOX];
    int          box_w [NBOX];
    int          box_h [NBOX];
    int          held;
    logic [28:0] area_limit;
    int          mismatches;
    answer_t     answers_due [$];

    function new();
      held       = 0;
      area_limit = 29'(MIN_AREA_RST);
      mismatches = 0;
    endfunction

    // boxes below the minimum area are invisible to every query
    function bit counts(int i);
      return longint'(box_w[i]) * longint'(box_h[i]) >= longint'(area_limit);
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // negative edges (zero size at 0) come out as 0
    function logic [CB:0] clip(int v);
      return (v < 0) ? '0 : v[CB:0];
    endfunction

    function answer_t answer_item(logic [FUNC_W-1:0] f, int px, int py, int sw, int sh);
      answer_t a;
      int      rx, ry, x0, y0, x1, y1, cx, cy, d, best_d, bdx, bdy, right, bottom;
      longint  area, best_area;
      bit      found, fx, fy;
      a = '0;
      rx = 0;
      ry = 0;
      found = 0;
      best_d = 0;
      best_area = 0;
      case (f)
        FN_CLEAR: held = 0;
        FN_ADD: begin
          if (held < NBOX) begin
            box_x[held] = px;
            box_y[held] = py;
            box_w[held] = sw;
            box_h[held] = sh;
            held++;
          end else begin
            a.table_full = 1'b1;
          end
        end
        FN_CONTAIN: begin
          // half-open containment, strictly smaller area replaces
          for (int i = 0; i < held; i++) begin
            x0 = box_x[i];
            y0 = box_y[i];
            area = longint'(box_w[i]) * longint'(box_h[i]);
            if (px >= x0 && px < x0 + box_w[i] && py >= y0 && py < y0 + box_h[i] &&
                counts(i) && (!found || area < best_area)) begin
              found = 1;
              best_area = area;
              rx = x0;
              ry = y0;
              a.out_w = box_w[i][CB-1:0];
              a.out_h = box_h[i][CB-1:0];
            end
          end
        end
        FN_BEGIN: begin
          rx = px;
          ry = py;
          for (int i = 0; i < held; i++) begin
            if (counts(i)) begin
              x0 = box_x[i];
              y0 = box_y[i];
              x1 = x0 + box_w[i] - 1;
              y1 = y0 + box_h[i] - 1;
              // corners in TL, TR, BL, BR order
              for (int k = 0; k < 4; k++) begin
                cx = k[0] ? x1 : x0;
                cy = k[1] ? y1 : y0;
                d = mag(px - cx) + mag(py - cy);
                if (!found || d < best_d) begin
                  found = 1;
                  best_d = d;
                  rx = cx;
                  ry = cy;
                end
              end
            end
          end
        end
        FN_END: begin
          right = px + sw - 1;
          bottom = py + sh - 1;
          rx = right;
          ry = bottom;
          fx = 0;
          fy = 0;
          bdx = 0;
          bdy = 0;
          for (int i = 0; i < held; i++) begin
            if (counts(i)) begin
              x0 = box_x[i];
              y0 = box_y[i];
              x1 = x0 + box_w[i] - 1;
              y1 = y0 + box_h[i] - 1;
              for (int k = 0; k < 4; k++) begin
                cx = k[0] ? x1 : x0;
                cy = k[1] ? y1 : y0;
                // inclusive rectangle, x and y picked on their own
                if (cx >= px && cx <= right && cy >= py && cy <= bottom) begin
                  if (!fx || mag(cx - right) < bdx) begin
                    fx = 1;
                    bdx = mag(cx - right);
                    rx = cx;
                  end
                  if (!fy || mag(cy - bottom) < bdy) begin
                    fy = 1;
                    bdy = mag(cy - bottom);
                    ry = cy;
                  end
                end
              end
            end
          end
          // landing on the top-left corner means the bottom-right one
          if (rx == px && ry == py) begin
            rx = right;
            ry = bottom;
          end
        end
        default: ;
      endcase
      a.out_x = clip(rx);
      a.out_y = clip(ry);
      a.entries = 9'(held);
      return a;
    endfunction

    function void take_item(logic [FUNC_W-1:0] f, int px, int py, int sw, int sh);
      answers_due.push_back(answer_item(f, px, py, sw, sh));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (answers_due.size() == 0) begin
        report("result transfer with no item waiting");
      end else begin
        want = answers_due.pop_front();
        if (got.out_x !== want.out_x)
          report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
        if (got.out_y !== want.out_y)
          report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
        if (got.out_w !== want.out_w)
          report($sformatf("out_w got %0d want %0d", got.out_w, want.out_w));
        if (got.out_h !== want.out_h)
          report($sformatf("out_h got %0d want %0d", got.out_h, want.out_h));
        if (got.table_full !== want.table_full)
          report($sformatf("table_full got %0b want %0b", got.table_full, want.table_full));
        if (got.entries !== want.entries)
          report($sformatf("entries got %0d want %0d", got.entries, want.entries));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2*CB:0]       cfg_min_box_area = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [CB-1:0]       in_pos_x = '0;
  logic [CB-1:0]       in_pos_y = '0;
  logic [CB-1:0]       in_size_w = '0;
  logic [CB-1:0]       in_size_h = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CB:0]         out_x;
  logic [CB:0]         out_y;
  logic [CB-1:0]       out_w;
  logic [CB-1:0]       out_h;
  logic                out_table_full;
  logic [8:0]          out_entries;

  box_table_mirror mirror = new();
  bit              steady = 0;      // both sides run without gaps while set
  int              items_counted = 0;
  int              answers_taken = 0;

  box_table_snap_query_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_box_area (cfg_min_box_area),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_size_w        (in_size_w),
    .in_size_h        (in_size_h),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_w            (out_w),
    .out_h            (out_h),
    .out_table_full   (out_table_full),
    .out_entries      (out_entries)
  );

  always #10 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one item after a random gap, return at the edge of its transfer
  task automatic offer_item(logic [FUNC_W-1:0] f, int px, int py, int sw, int sh);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_pos_x  <= CB'(px);
    in_pos_y  <= CB'(py);
    in_size_w <= CB'(sw);
    in_size_h <= CB'(sh);
    do @(posedge clk); while (in_stall);
    mirror.take_item(f, px, py, sw, sh);
    if (f <= FN_END) items_counted++;
  endtask

  // drop valid and wait until every answer is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_area_limit(logic [2*CB:0] v);
    cfg_valid        <= 1'b1;
    cfg_min_box_area <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.area_limit = v;
  endtask

  // fully random fields and codes, unused ones included
  task automatic offer_noise();
    offer_item(FUNC_W'($urandom_range(0, FN_TOP)), $urandom_range(0, CMAX),
               $urandom_range(0, CMAX), $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endtask

  // box placed in the scene window, mostly small, now and then any size
  task automatic offer_box(int bx, int by);
    int w, h;
    w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, CMAX) : $urandom_range(0, 60);
    h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, CMAX) : $urandom_range(0, 60);
    offer_item(FN_ADD, bx + $urandom_range(0, 200), by + $urandom_range(0, 200), w, h);
  endtask

  // point query or end rectangle inside the scene window
  task automatic offer_query(int bx, int by);
    logic [FUNC_W-1:0] f;
    f = FUNC_W'($urandom_range(FN_CONTAIN, FN_END));
    if (f == FN_END)
      offer_item(f, bx + $urandom_range(0, 120), by + $urandom_range(0, 120),
                 $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 260),
                 $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 260));
    else
      // sizes are don't-care for point queries, still toggled
      offer_item(f, bx + $urandom_range(0, 260), by + $urandom_range(0, 260),
                 $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endtask

  function automatic int window_base();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return CMAX - WIN;
      default: return $urandom_range(0, CMAX - WIN);
    endcase
  endfunction

  // one well-formed scene: usually a clear, a few boxes, then queries
  task automatic play_scene();
    int bx, by, nadd, nq, pick;
    steady = ($urandom_range(0, 4) == 0);
    bx = window_base();
    by = window_base();
    if ($urandom_range(0, 4) != 0) offer_item(FN_CLEAR, bx, by, 0, 0);
    nadd = $urandom_range(0, 12);
    for (int i = 0; i < nadd; i++) offer_box(bx, by);
    nq = $urandom_range(2, 10);
    for (int i = 0; i < nq; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) offer_noise();
      else if (pick == 1) offer_box(bx, by);
      else offer_query(bx, by);
    end
  endtask

  // run the table past full, then a few long scans
  task automatic fill_table();
    int bx, by, n;
    steady = ($urandom_range(0, 1) == 0);
    bx = window_base();
    by = window_base();
    offer_item(FN_CLEAR, 0, 0, 0, 0);
    n = NBOX + $urandom_range(2, 6);
    for (int i = 0; i < n; i++) offer_box(bx, by);
    for (int i = 0; i < 6; i++) offer_query(bx, by);
  endtask

  // result side: random stalls, two long hold-offs to back the block up
  initial begin
    int     pause;
    answer_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pause = steady ? 0 : $urandom_range(0, 7);
      if (answers_taken == 40 || answers_taken == 900) pause = 500;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.out_x      = out_x;
      got.out_y      = out_y;
      got.out_w      = out_w;
      got.out_h      = out_h;
      got.table_full = out_table_full;
      got.entries    = out_entries;
      mirror.check_answer(got);
      answers_taken++;
    end
  end

  // stimulus: directed checks, then random phases at several area limits
  initial begin
    int          goal;
    int          phase_len [6];
    logic [28:0] phase_area [6];
    phase_len  = '{400, 350, 100, 400, 100, 450};
    phase_area = '{29'($urandom_range(0, 64)), 29'd0, 29'h0FFF_FFFF,
                   29'($urandom_range(1, 400)), 29'h1000_0000, 29'(MIN_AREA_RST)};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: contain gives zeros, begin gives the point,
    // end of a zero-size rectangle at 0 has negative edges
    offer_item(FN_CONTAIN, 5, 5, 0, 0);
    offer_item(FN_BEGIN, CMAX, CMAX, CMAX, CMAX);
    offer_item(FN_END, 0, 0, 0, 0);
    offer_item(FN_END, 10, 10, 1, 1);
    // reset limit of 32 hides the 4x4 box; duplicate tests first-wins
    offer_item(FN_ADD, 100, 100, 10, 10);
    offer_item(FN_ADD, 102, 102, 4, 4);
    offer_item(FN_ADD, 100, 100, 10, 10);
    offer_item(FN_ADD, 0, 0, 0, 0);
    offer_item(FN_ADD, CMAX, CMAX, CMAX, CMAX);
    offer_item(FN_CONTAIN, 103, 103, 0, 0);
    offer_item(FN_CONTAIN, 110, 105, 0, 0);   // right edge is open
    offer_item(FN_CONTAIN, 109, 109, CMAX, CMAX);
    offer_item(FN_CONTAIN, CMAX, CMAX, 0, 0);
    offer_item(FN_BEGIN, 104, 100, 0, 0);
    offer_item(FN_BEGIN, 0, 0, 0, 0);
    offer_item(FN_END, 95, 95, 20, 20);
    offer_item(FN_END, 100, 100, 5, 5);       // only the top-left fits
    offer_item(FN_END, CMAX, CMAX, CMAX, CMAX);
    for (int f = FN_END + 1; f <= FN_TOP; f++) offer_item(FUNC_W'(f), 7, 7, 7, 7);
    settle();
    // zero limit lets the empty box through, its corners go negative
    write_area_limit('0);
    offer_item(FN_BEGIN, 0, 5, 0, 0);
    offer_item(FN_END, 0, 0, 3, 3);
    offer_item(FN_CONTAIN, 0, 0, 0, 0);
    offer_item(FN_CLEAR, CMAX, CMAX, CMAX, CMAX);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_area_limit(phase_area[p]);
      goal = items_counted + phase_len[p];
      if (p == 3) fill_table();
      while (items_counted < goal) play_scene();
      settle();
    end

    // trailing window for stray results, about one full scan
    repeat (NBOX + 16) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
